// File: rtl/core/lasd_pkg.sv
package lasd_pkg;

  localparam int MAX_SLOTS     = 8;
  localparam int DEF_SLOTS     = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int STEP_BITS     = 16;
  localparam int DUR_W         = 8;
  localparam int TIME_W        = 32;
  localparam int IDX_W         = 4;
  localparam int REP_W         = 11;
  localparam int BLANK_MS      = 30;
  localparam int HOLD_MS       = 45;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ACTIVITY = 2'd1,
    CMD_SET_MODE = 2'd2,
    CMD_START    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_SEQ     = 2'd2,
    MODE_OFF_ALT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_LOW  = 8'd0,
    REG_STEPS_HIGH = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
  } step_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [1:0]              mode_value;
    logic signed [REP_W-1:0] repeat_count;
  } item_t;

  // duration field in 10 ms units, as a time offset
  function automatic logic [TIME_W-1:0] dur_ms(input logic [DUR_W-1:0] d);
    logic [DUR_W+3:0] m;
    m = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
    return {{(TIME_W-DUR_W-4){1'b0}}, m};
  endfunction

endpackage

// File: rtl/core/lasd_ifs.sv
interface lasd_item_if;
  import lasd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [1:0]              mode_value;
  logic signed [REP_W-1:0] repeat_count;
  modport source (output valid, command, mode_value, repeat_count, input ready);
  modport sink (input valid, command, mode_value, repeat_count, output ready);
endinterface

interface lasd_result_if;
  logic valid;
  logic ready;
  logic led_on;
  logic sequence_running;
  modport source (output valid, led_on, sequence_running, input ready);
  modport sink (input valid, led_on, sequence_running, output ready);
endinterface

interface lasd_cfg_if;
  import lasd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/lasd_cfg_regs.sv
module lasd_cfg_regs
  import lasd_pkg::*;
#(
  parameter int STEP_SLOTS = DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  lasd_cfg_if.sink         cfg,
  input  logic [IDX_W-1:0] rd_idx,
  output step_t            step_k,
  output step_t            step_0
);

  localparam int SLOT_W = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
  localparam int LANES  = CFG_DATA_W / STEP_BITS;

  step_t steps [STEP_SLOTS];

  assign cfg.ready = 1'b1;

  for (genvar s = 0; s < STEP_SLOTS; s++) begin : g_slot
    localparam int LANE = s % LANES;
    localparam reg_idx_t WSEL = (s / LANES == 0) ? REG_STEPS_LOW : REG_STEPS_HIGH;
    always_ff @(posedge clk) begin
      if (rst) begin
        steps[s] <= '0;
      end else if (cfg.valid && cfg.index == WSEL) begin
        steps[s] <= {cfg.data[LANE*STEP_BITS+DUR_W], cfg.data[LANE*STEP_BITS +: DUR_W]};
      end
    end
  end

  // indexes past the stored steps read as an end step, dark
  always_comb begin
    if ({{(32-IDX_W){1'b0}}, rd_idx} < STEP_SLOTS) begin
      step_k = steps[rd_idx[SLOT_W-1:0]];
    end else begin
      step_k = '0;
    end
  end

  assign step_0 = steps[0];

endmodule

// File: rtl/core/lasd_seq_core.sv
module lasd_seq_core
  import lasd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  item_t            item,
  input  step_t            step_k,
  input  step_t            step_0,
  output logic [IDX_W-1:0] rd_idx,
  output logic             led_next,
  output logic             running_next
);

  logic [TIME_W-1:0] now_ms, blank_until, hold_until, next_time;
  logic [IDX_W-1:0]  step_index;
  logic [REP_W-1:0]  repeats_left;
  mode_t             cur_mode;
  logic              seq_active;
  logic              led_level;

  logic [TIME_W-1:0] now_ms_next, blank_until_next, hold_until_next, next_time_next;
  logic [IDX_W-1:0]  step_index_next;
  logic [REP_W-1:0]  repeats_left_next;
  mode_t             cur_mode_next;
  logic              seq_active_next;

  // state after the command itself, before the mode update
  logic [TIME_W-1:0] next_a, t0, tk;
  logic [IDX_W-1:0]  idx_a;
  logic              led_a;
  logic              cmd_start;

  assign cmd_start = (cmd_t'(item.command) == CMD_START);
  assign idx_a     = cmd_start ? '0 : step_index;
  assign rd_idx    = idx_a + 1'b1;
  assign t0        = now_ms_next + dur_ms(step_0.dur);
  assign tk        = now_ms_next + dur_ms(step_k.dur);

  always_comb begin
    now_ms_next       = now_ms;
    blank_until_next  = blank_until;
    hold_until_next   = hold_until;
    cur_mode_next     = cur_mode;
    seq_active_next   = seq_active;
    repeats_left_next = repeats_left;
    case (cmd_t'(item.command))
      CMD_TICK: now_ms_next = now_ms + 1'b1;
      CMD_ACTIVITY: begin
        if (hold_until < now_ms && blank_until < now_ms) begin
          blank_until_next = now_ms + TIME_W'(BLANK_MS);
          hold_until_next  = now_ms + TIME_W'(HOLD_MS);
        end
      end
      CMD_SET_MODE: cur_mode_next = mode_t'(item.mode_value);
      CMD_START: begin
        cur_mode_next     = MODE_SEQ;
        seq_active_next   = 1'b1;
        repeats_left_next = item.repeat_count;
      end
      default: ;
    endcase

    next_a = cmd_start ? t0 : next_time;
    led_a  = cmd_start ? step_0.level : led_level;

    step_index_next = idx_a;
    next_time_next  = next_a;
    led_next        = led_a;
    case (cur_mode_next)
      MODE_NORMAL: led_next = (blank_until_next < now_ms_next);
      MODE_SEQ: begin
        if (seq_active_next && now_ms_next > next_a) begin
          step_index_next = rd_idx;
          led_next        = step_k.level;
          next_time_next  = tk;
          if (step_k.dur == '0) begin
            if (repeats_left_next != '0) begin
              if (!repeats_left_next[REP_W-1]) begin
                repeats_left_next = repeats_left_next - 1'b1;
              end
              step_index_next = '0;
              led_next        = step_0.level;
              next_time_next  = t0;
            end else begin
              seq_active_next = 1'b0;
            end
          end
        end
      end
      default: led_next = 1'b0;
    endcase

    running_next = seq_active_next && (cur_mode_next == MODE_SEQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms       <= '0;
      blank_until  <= '0;
      hold_until   <= '0;
      next_time    <= '0;
      step_index   <= '0;
      repeats_left <= '0;
      cur_mode     <= MODE_OFF;
      seq_active   <= 1'b0;
      led_level    <= 1'b0;
    end else if (fire) begin
      now_ms       <= now_ms_next;
      blank_until  <= blank_until_next;
      hold_until   <= hold_until_next;
      next_time    <= next_time_next;
      step_index   <= step_index_next;
      repeats_left <= repeats_left_next;
      cur_mode     <= cur_mode_next;
      seq_active   <= seq_active_next;
      led_level    <= led_next;
    end
  end

endmodule

// File: rtl/core/led_activity_sequence_driver.sv
// LED activity and sequence driver.
//
// items: one word per command (tick, activity, set mode, start sequence).
// results: one word per item, the LED level and whether a sequence is
// still playing after that item.
// cfg: writes the two step words (index 0 steps 0-3, index 1 steps 4-7);
// it is always ready and should only be written while the block is idle.
//
// The item is captured in an input register at the accepting edge, the
// timer and sequence state update in one pass of compares and 32-bit
// adds, and the result is registered once the result register is free.
// Throughput is one item per cycle while results are taken; while a
// result waits, only the input register can still take a word, so a
// stall on results only backs up into items once both registers are
// full.
//
// Reset clears the timers, mode (off), the sequence state, the LED and
// both step words; no result is pending after reset.
module led_activity_sequence_driver
  import lasd_pkg::*;
#(
  parameter int STEP_SLOTS = DEF_SLOTS
) (
  input logic           clk,
  input logic           rst,
  lasd_item_if.sink     items,
  lasd_result_if.source results,
  lasd_cfg_if.sink      cfg
);

  item_t            item;
  logic             item_valid;
  logic             fire;
  logic [IDX_W-1:0] rd_idx;
  step_t            step_k, step_0;
  logic             led_next, running_next;

  // the state pass runs when a word is held and the result register frees up
  assign fire        = item_valid && (!results.valid || results.ready);
  assign items.ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item <= '{command: items.command, mode_value: items.mode_value,
                repeat_count: items.repeat_count};
    end
  end

  lasd_cfg_regs #(.STEP_SLOTS(STEP_SLOTS)) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .rd_idx (rd_idx),
    .step_k (step_k),
    .step_0 (step_0)
  );

  lasd_seq_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item),
    .step_k       (step_k),
    .step_0       (step_0),
    .rd_idx       (rd_idx),
    .led_next     (led_next),
    .running_next (running_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.led_on           <= led_next;
      results.sequence_running <= running_next;
    end
  end

endmodule

// File: tb/sv/led_result_monitor.sv
module led_result_monitor
  import lasd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic                    item_ready,
  input  logic [1:0]              command,
  input  logic [1:0]              mode_value,
  input  logic signed [REP_W-1:0] repeat_count,
  input  logic                    res_valid,
  input  logic                    res_ready,
  input  logic                    led_on,
  input  logic                    sequence_running,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic led;
    logic run;
  } led_word_t;

  led_word_t led_word_q[$];

  // model copy of the block state
  logic [CFG_DATA_W-1:0]   steps_lo, steps_hi;
  logic [TIME_W-1:0]       ms_count, blank_end, hold_end, step_deadline;
  logic [IDX_W-1:0]        step_ptr;
  logic signed [REP_W-1:0] passes_left;
  mode_t                   cur_mode;
  logic                    seq_on;
  logic                    led_lvl;

  function automatic logic [STEP_BITS-1:0] step_word(input logic [IDX_W-1:0] k);
    logic [CFG_DATA_W-1:0] w;
    if (k >= DEF_SLOTS) return '0;
    w = (k < 4) ? steps_lo : steps_hi;
    return w[16*k[1:0] +: 16];
  endfunction

  task automatic load_step(input logic [IDX_W-1:0] k, output logic zero_dur);
    logic [STEP_BITS-1:0] s;
    s = step_word(k);
    step_ptr = k;
    led_lvl = s[8];
    step_deadline = ms_count + TIME_W'(s[7:0]) * 10;
    zero_dur = (s[7:0] == '0);
  endtask

  task automatic led_drive_predict(input logic [1:0] cmd, input logic [1:0] mv,
                                   input logic signed [REP_W-1:0] rep,
                                   output led_word_t w);
    logic z;
    case (cmd_t'(cmd))
      CMD_TICK: ms_count = ms_count + 1;
      CMD_ACTIVITY: begin
        if (hold_end < ms_count && blank_end < ms_count) begin
          blank_end = ms_count + TIME_W'(BLANK_MS);
          hold_end  = ms_count + TIME_W'(HOLD_MS);
        end
      end
      CMD_SET_MODE: cur_mode = mode_t'(mv);
      default: begin
        cur_mode = MODE_SEQ;
        seq_on = 1'b1;
        passes_left = rep;
        load_step('0, z);
      end
    endcase
    case (cur_mode)
      MODE_NORMAL: led_lvl = (blank_end < ms_count);
      MODE_SEQ: begin
        if (seq_on && ms_count > step_deadline) begin
          load_step(step_ptr + 1'b1, z);
          // a zero duration ends the pass: restart or stop
          if (z) begin
            if (passes_left != 0) begin
              if (passes_left > 0) passes_left = passes_left - 1'b1;
              load_step('0, z);
            end else begin
              seq_on = 1'b0;
            end
          end
        end
      end
      default: led_lvl = 1'b0;
    endcase
    w.led = led_lvl;
    w.run = seq_on && (cur_mode == MODE_SEQ);
  endtask

  always @(posedge clk) begin
    led_word_t w, e;
    if (rst) begin
      steps_lo = '0;
      steps_hi = '0;
      ms_count = '0;
      blank_end = '0;
      hold_end = '0;
      step_deadline = '0;
      step_ptr = '0;
      passes_left = '0;
      cur_mode = MODE_OFF;
      seq_on = 1'b0;
      led_lvl = 1'b0;
      led_word_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEPS_LOW) steps_lo = cfg_data;
        else if (cfg_index == REG_STEPS_HIGH) steps_hi = cfg_data;
      end
      if (item_valid && item_ready) begin
        led_drive_predict(command, mode_value, repeat_count, w);
        led_word_q.push_back(w);
      end
      if (res_valid && res_ready) begin
        if (led_word_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result word: led_on %0b sequence_running %0b",
                     led_on, sequence_running);
          errors++;
        end else begin
          e = led_word_q.pop_front();
          if (e.led !== led_on || e.run !== sequence_running) begin
            if (errors < 10)
              $display("mismatch: led_on exp %0b got %0b, sequence_running exp %0b got %0b",
                       e.led, led_on, e.run, sequence_running);
            errors++;
          end
        end
      end
    end
    pending = led_word_q.size();
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  import lasd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int SRC_IDLE_PCT   = 45;
  localparam int SINK_STALL_PCT = 45;
  localparam int BOTH_PCT       = 15;

  typedef enum int {
    STEPS_ZERO,
    STEPS_ONES,
    STEPS_SHORT,
    STEPS_MIXED
  } steps_style_t;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   errors;
  int   pending;

  lasd_item_if   item_ch ();
  lasd_result_if res_ch ();
  lasd_cfg_if    cfg_ch ();

  led_activity_sequence_driver u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  led_result_monitor u_mon (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_ch.valid),
    .item_ready       (item_ch.ready),
    .command          (item_ch.command),
    .mode_value       (item_ch.mode_value),
    .repeat_count     (item_ch.repeat_count),
    .res_valid        (res_ch.valid),
    .res_ready        (res_ch.ready),
    .led_on           (res_ch.led_on),
    .sequence_running (res_ch.sequence_running),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .errors           (errors),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // step words: duration in bits 7:0, level in bit 8, the rest is junk
  function automatic logic [63:0] make_steps(input steps_style_t style);
    logic [63:0] w;
    logic [15:0] s;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      s = 16'($urandom);
      case (style)
        STEPS_ZERO:  s = '0;
        STEPS_ONES:  s = '1;
        STEPS_SHORT: s[7:0] = 8'($urandom_range(3, 1));
        default:     s[7:0] = ($urandom_range(9) == 0) ? 8'($urandom) :
                              8'($urandom_range(3));
      endcase
      w[16*k +: 16] = s;
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // only touch the step words once every result is back
  task automatic configure(input steps_style_t lo_style, input steps_style_t hi_style,
                           input bit junk_write);
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    write_reg(REG_STEPS_LOW, make_steps(lo_style));
    write_reg(REG_STEPS_HIGH, make_steps(hi_style));
    if (junk_write)
      write_reg(CFG_IDX_W'($urandom_range(255, 2)), {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(input cmd_t cmd, input logic [1:0] mv,
                           input logic signed [REP_W-1:0] rep);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.command      <= cmd;
    item_ch.mode_value   <= mv;
    item_ch.repeat_count <= rep;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_random_item();
    int r;
    logic signed [REP_W-1:0] rep;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0:       rep = -1;
      1:       rep = REP_W'($urandom_range(3));
      2:       rep = REP_W'($urandom_range(1));
      default: rep = REP_W'($urandom);
    endcase
    if (r < 62)      send_item(CMD_TICK, 2'($urandom), REP_W'($urandom));
    else if (r < 72) send_item(CMD_ACTIVITY, 2'($urandom), REP_W'($urandom));
    else if (r < 84) send_item(CMD_SET_MODE, 2'($urandom), REP_W'($urandom));
    else             send_item(CMD_START, 2'($urandom), rep);
  endtask

  task automatic set_idling(input int sel);
    case (sel % 4)
      0: begin src_idle_pct = 0;            sink_stall_pct = 0;              end
      1: begin src_idle_pct = SRC_IDLE_PCT; sink_stall_pct = 0;              end
      2: begin src_idle_pct = 0;            sink_stall_pct = SINK_STALL_PCT; end
      default: begin src_idle_pct = BOTH_PCT; sink_stall_pct = BOTH_PCT;     end
    endcase
  endtask

  initial begin
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.command      <= CMD_TICK;
    item_ch.mode_value   <= MODE_OFF;
    item_ch.repeat_count <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_STEPS_LOW;
    cfg_ch.data          <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: modes, blanking, sequence starts with repeat extremes
    configure(STEPS_SHORT, STEPS_SHORT, 1'b1);
    send_item(CMD_TICK, MODE_OFF_ALT, -1);
    send_item(CMD_SET_MODE, MODE_NORMAL, '0);
    send_item(CMD_ACTIVITY, MODE_SEQ, 1023);
    send_item(CMD_TICK, MODE_OFF, '0);
    send_item(CMD_ACTIVITY, MODE_NORMAL, '0);
    send_item(CMD_SET_MODE, MODE_OFF_ALT, -1024);
    send_item(CMD_ACTIVITY, MODE_OFF, '0);
    send_item(CMD_SET_MODE, MODE_OFF, '0);
    send_item(CMD_SET_MODE, MODE_SEQ, '0);
    send_item(CMD_START, MODE_OFF_ALT, '0);
    repeat (5) send_item(CMD_TICK, MODE_NORMAL, 1);
    send_item(CMD_START, MODE_OFF, -1);
    repeat (3) send_item(CMD_TICK, MODE_OFF, '0);
    send_item(CMD_START, MODE_NORMAL, 1023);
    send_item(CMD_TICK, MODE_SEQ, '0);
    send_item(CMD_START, MODE_SEQ, -1024);
    send_item(CMD_SET_MODE, MODE_NORMAL, -1);
    send_item(CMD_TICK, MODE_OFF_ALT, '1);
    item_ch.valid <= 1'b0;

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_idling(p);
      case (p)
        0:       configure(STEPS_ZERO, STEPS_ZERO, 1'b0);
        1:       configure(STEPS_ONES, STEPS_ONES, 1'b1);
        2:       configure(STEPS_SHORT, STEPS_SHORT, 1'b0);
        3:       configure(STEPS_SHORT, STEPS_ZERO, 1'b1);
        default: configure(STEPS_MIXED, STEPS_MIXED, p[0]);
      endcase
      repeat (PHASE_ITEMS) send_random_item();
      item_ch.valid <= 1'b0;
    end

    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("** led_activity_sequence_driver: PASSED **");
    else
      $display("** led_activity_sequence_driver: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** led_activity_sequence_driver: FAILED **");
    $finish;
  end

endmodule
